FILE: src/laev_pkg.sv
`default_nettype none

package laev_pkg;

    // Sample width of the audio path.
    localparam int SAMPLE_BITS = 24;

    // Default depth of the tanh table.
    localparam int unsigned TANH_ENTRIES_DEF = 256;

    // Shared multiplier: operand A carries the sample magnitude or the
    // tanh argument (21 bits), operand B is at most 17 bits.
    localparam int MUL_A_W = (SAMPLE_BITS > 21) ? SAMPLE_BITS : 21;
    localparam int MUL_B_W = 17;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;

    localparam int ADDR_W = 5;

    // Register map, word index
    localparam logic [2:0] REG_ATTACK_MULT  = 3'd0;
    localparam logic [2:0] REG_RELEASE_MULT = 3'd1;
    localparam logic [2:0] REG_LOOP_ENABLE  = 3'd2;
    localparam logic [2:0] REG_SILENT_LEVEL = 3'd3;
    localparam logic [2:0] REG_KNEE_INVERSE = 3'd4;

    localparam logic [15:0] ATTACK_MULT_RST  = 16'd64881;
    localparam logic [15:0] RELEASE_MULT_RST = 16'd64881;
    localparam logic        LOOP_ENABLE_RST  = 1'b0;
    localparam logic [15:0] SILENT_LEVEL_RST = 16'd33;
    localparam logic [15:0] KNEE_INVERSE_RST = 16'd4096;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_ATTACK  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_RESET   = 2'd3;

    localparam logic [1:0] STAGE_IDLE    = 2'd0;
    localparam logic [1:0] STAGE_ATTACK  = 2'd1;
    localparam logic [1:0] STAGE_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [15:0]                   env_level;
        logic [1:0]                    env_stage;
        logic                          block_last;
    } out_t;

    // Datapath operations
    localparam logic [3:0] OP_WAIT       = 4'd0;
    localparam logic [3:0] OP_CMD        = 4'd1;
    localparam logic [3:0] OP_MUL_KNEE   = 4'd2;
    localparam logic [3:0] OP_AX         = 4'd3;
    localparam logic [3:0] OP_MUL_N      = 4'd4;
    localparam logic [3:0] OP_INDEX      = 4'd5;
    localparam logic [3:0] OP_ROM_LO     = 4'd6;
    localparam logic [3:0] OP_ROM_HI     = 4'd7;
    localparam logic [3:0] OP_MUL_D      = 4'd8;
    localparam logic [3:0] OP_INTERP     = 4'd9;
    localparam logic [3:0] OP_MUL_STEP   = 4'd10;
    localparam logic [3:0] OP_LEVEL      = 4'd11;
    localparam logic [3:0] OP_STAGE      = 4'd12;
    localparam logic [3:0] OP_MUL_SAMPLE = 4'd13;
    localparam logic [3:0] OP_EMIT       = 4'd14;

    // Hold conditions: stay on the step and suppress its operation
    localparam logic [1:0] HOLD_NONE     = 2'd0;
    localparam logic [1:0] HOLD_NO_ITEM  = 2'd1;
    localparam logic [1:0] HOLD_OUT_BUSY = 2'd2;

    // Jump conditions
    localparam logic [2:0] J_NEVER      = 3'd0;
    localparam logic [2:0] J_ALWAYS     = 3'd1;
    localparam logic [2:0] J_NOT_SAMPLE = 3'd2;
    localparam logic [2:0] J_AT_TARGET  = 3'd3;
    localparam logic [2:0] J_CLAMP      = 3'd4;

    // Program steps
    localparam logic [3:0] S_WAIT       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_MUL_KNEE   = 4'd2;
    localparam logic [3:0] S_AX         = 4'd3;
    localparam logic [3:0] S_MUL_N      = 4'd4;
    localparam logic [3:0] S_INDEX      = 4'd5;
    localparam logic [3:0] S_ROM_LO     = 4'd6;
    localparam logic [3:0] S_ROM_HI     = 4'd7;
    localparam logic [3:0] S_MUL_D      = 4'd8;
    localparam logic [3:0] S_INTERP     = 4'd9;
    localparam logic [3:0] S_MUL_STEP   = 4'd10;
    localparam logic [3:0] S_LEVEL      = 4'd11;
    localparam logic [3:0] S_STAGE      = 4'd12;
    localparam logic [3:0] S_MUL_SAMPLE = 4'd13;
    localparam logic [3:0] S_EMIT       = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] hold;
        logic [2:0] jcond;
        logic [3:0] jtgt;
    } ucode_t;

    function automatic ucode_t ucode_word(input logic [3:0] step);
        ucode_t w;
        w = '{op: OP_WAIT, hold: HOLD_NONE, jcond: J_NEVER, jtgt: S_WAIT};
        unique case (step)
            S_WAIT:       w = '{OP_WAIT,       HOLD_NO_ITEM,  J_NEVER,      S_WAIT};
            S_DECODE:     w = '{OP_CMD,        HOLD_NONE,     J_NOT_SAMPLE, S_WAIT};
            S_MUL_KNEE:   w = '{OP_MUL_KNEE,   HOLD_NONE,     J_AT_TARGET,  S_STAGE};
            S_AX:         w = '{OP_AX,         HOLD_NONE,     J_NEVER,      S_WAIT};
            S_MUL_N:      w = '{OP_MUL_N,      HOLD_NONE,     J_NEVER,      S_WAIT};
            S_INDEX:      w = '{OP_INDEX,      HOLD_NONE,     J_NEVER,      S_WAIT};
            S_ROM_LO:     w = '{OP_ROM_LO,     HOLD_NONE,     J_NEVER,      S_WAIT};
            S_ROM_HI:     w = '{OP_ROM_HI,     HOLD_NONE,     J_CLAMP,      S_MUL_STEP};
            S_MUL_D:      w = '{OP_MUL_D,      HOLD_NONE,     J_NEVER,      S_WAIT};
            S_INTERP:     w = '{OP_INTERP,     HOLD_NONE,     J_NEVER,      S_WAIT};
            S_MUL_STEP:   w = '{OP_MUL_STEP,   HOLD_NONE,     J_NEVER,      S_WAIT};
            S_LEVEL:      w = '{OP_LEVEL,      HOLD_NONE,     J_NEVER,      S_WAIT};
            S_STAGE:      w = '{OP_STAGE,      HOLD_NONE,     J_NEVER,      S_WAIT};
            S_MUL_SAMPLE: w = '{OP_MUL_SAMPLE, HOLD_NONE,     J_NEVER,      S_WAIT};
            S_EMIT:       w = '{OP_EMIT,       HOLD_OUT_BUSY, J_ALWAYS,     S_WAIT};
            default:      w = '{OP_WAIT,       HOLD_NONE,     J_ALWAYS,     S_WAIT};
        endcase
        return w;
    endfunction

    // Shift-subtract division, used only while building the tanh table.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry k of round(32768 * tanh(4k/n)), built in Q.24 from a series
    // for e^(8/n) and repeated rounded products.
    function automatic logic [15:0] tanh_entry(input int unsigned n, input int unsigned k);
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] res;
        one  = 64'd1 << 24;
        y    = udiv64(64'd8 << 24, 64'(n));
        term = one;
        e    = one;
        p    = one;
        for (int unsigned i = 1; i <= 12; i++) begin
            term = udiv64((term * y) >> 24, 64'(i));
            e    = e + term;
        end
        for (int unsigned i = 0; i < k; i++) begin
            p = (p * e + (one >> 1)) >> 24;
        end
        num = (p - one) << 15;
        den = p + one;
        res = udiv64(num + (den >> 1), den);
        return res[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/laev_tanh_rom.sv
`default_nettype none

module laev_tanh_rom #(
    parameter int unsigned ENTRIES = laev_pkg::TANH_ENTRIES_DEF,
    localparam int         AW      = $clog2(ENTRIES)
) (
    input  logic          clk,
    input  logic [AW-1:0] addr,
    output logic [15:0]   q
);

    logic [15:0] rom [ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam logic [15:0] ENTRY = laev_pkg::tanh_entry(ENTRIES, k);
        assign rom[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        q <= rom[addr];
    end

endmodule

`default_nettype wire

FILE: src/looping_ar_envelope_vca.sv
// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall  in_data   (cmd, sample_in, block_end)
// out       from block out_valid / out_stall out_data (sample_out, env_level,
//                                                      env_stage, block_last)
// config    to block   APB psel/penable     paddr, pwdata, prdata
//
// A command item runs only the decode step. A sample item runs the step
// sequence of the microcode program over one shared multiplier and one ROM
// port, skipping interpolation when the tanh argument runs past the table,
// and jumping to the stage update when the level already sits on its target.
// The next item is taken while the last result waits in the output register.
// A stalled output holds the program at its last step.
// Reset clears the envelope state and loads the register defaults; the tanh
// table is constant, so no clearing pass follows reset.
`default_nettype none

module looping_ar_envelope_vca #(
    parameter int unsigned TANH_ENTRIES = laev_pkg::TANH_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  laev_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output laev_pkg::out_t                 out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [laev_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SB    = laev_pkg::SAMPLE_BITS;
    localparam int MA_W  = laev_pkg::MUL_A_W;
    localparam int MB_W  = laev_pkg::MUL_B_W;
    localparam int MW    = laev_pkg::MUL_W;
    localparam int IW    = $clog2(TANH_ENTRIES);
    localparam int IHI_W = MW - 17;
    localparam logic [IHI_W-1:0] LAST_IDX = IHI_W'(TANH_ENTRIES - 1);
    localparam logic [IW-1:0]    LAST_ADDR = IW'(TANH_ENTRIES - 1);
    localparam logic [MB_W-1:0]  N_MUL = MB_W'(TANH_ENTRIES);
    localparam logic [SB:0]      POS_LIM = {2'b00, {(SB-1){1'b1}}};
    localparam logic [SB:0]      NEG_LIM = {2'b01, {(SB-1){1'b0}}};
    localparam logic [SB-1:0]    SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]    SMIN = {1'b1, {(SB-1){1'b0}}};

    // Sequencer
    logic [3:0]       step_reg, step_next;
    laev_pkg::ucode_t uc;
    logic             hold_now;
    logic             active;
    logic             jump_now;

    // Configuration and envelope state
    logic [15:0] attack_mult_reg, attack_mult_next;
    logic [15:0] release_mult_reg, release_mult_next;
    logic        loop_enable_reg, loop_enable_next;
    logic [15:0] silent_level_reg, silent_level_next;
    logic [15:0] knee_inverse_reg, knee_inverse_next;
    logic [15:0] level_reg, level_next;
    logic [1:0]  stage_reg, stage_next;
    logic [15:0] step_mult_reg, step_mult_next;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    // Datapath
    laev_pkg::in_t     item_reg;
    logic [16:0]       diff_reg;
    logic [16:0]       diff_calc;
    logic              up_reg;
    logic [MW-1:0]     prod_reg;
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [MW-1:0]     mul_p;
    logic [20:0]       ax_reg;
    logic [32:0]       ax_sum;
    logic [IW-1:0]     idx_reg;
    logic [16:0]       rem_reg;
    logic              clamp_reg;
    logic [15:0]       lo_reg;
    logic [15:0]       t_reg;
    logic [15:0]       delta;
    logic [33:0]       interp_sum;
    logic [16:0]       t_interp;
    logic [32:0]       stepv_sum;
    logic [16:0]       stepv;
    logic [16:0]       level_up;
    logic [15:0]       level_upd;
    logic [1:0]        stage_upd;
    logic [15:0]       sm_upd;
    logic              silent;
    logic [IW-1:0]     rom_addr;
    logic [15:0]       rom_q;
    logic              smp_neg;
    logic [SB-1:0]     smp_abs;
    logic [SB+15:0]    mag_sum;
    logic [SB:0]       mag;
    logic [SB:0]       mag_neg;
    logic [SB-1:0]     smp_res;
    laev_pkg::out_t    out_reg;
    logic              out_valid_reg;

    assign uc = laev_pkg::ucode_word(step_reg);

    always_comb
    begin
        hold_now = 1'b0;
        case (uc.hold)
            laev_pkg::HOLD_NO_ITEM:  hold_now = !in_valid;
            laev_pkg::HOLD_OUT_BUSY: hold_now = out_valid_reg && out_stall;
            default:                 hold_now = 1'b0;
        endcase
    end

    assign active = !hold_now;

    always_comb
    begin
        jump_now = 1'b0;
        case (uc.jcond)
            laev_pkg::J_ALWAYS:     jump_now = 1'b1;
            laev_pkg::J_NOT_SAMPLE: jump_now = item_reg.cmd != laev_pkg::CMD_SAMPLE;
            laev_pkg::J_AT_TARGET:  jump_now = diff_reg == 17'd0;
            laev_pkg::J_CLAMP:      jump_now = clamp_reg;
            default:                jump_now = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold_now)
            step_next = step_reg;
        else if (jump_now)
            step_next = uc.jtgt;
        else
            step_next = step_reg + 4'd1;
    end

    assign in_stall = step_reg != laev_pkg::S_WAIT;

    // Distance to target: 1.0 in attack, zero otherwise
    assign diff_calc = (stage_reg == laev_pkg::STAGE_ATTACK)
                     ? (17'h10000 - {1'b0, level_reg})
                     : {1'b0, level_reg};

    assign smp_neg = item_reg.sample_in[SB-1];
    assign smp_abs = smp_neg ? SB'(~item_reg.sample_in + 1'b1) : SB'(item_reg.sample_in);

    assign delta = (rom_q > lo_reg) ? (rom_q - lo_reg) : 16'd0;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.op)
            laev_pkg::OP_MUL_KNEE:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = {1'b0, knee_inverse_reg};
            end
            laev_pkg::OP_MUL_N:
            begin
                mul_a = MA_W'(ax_reg);
                mul_b = N_MUL;
            end
            laev_pkg::OP_MUL_D:
            begin
                mul_a = MA_W'(rem_reg);
                mul_b = {1'b0, delta};
            end
            laev_pkg::OP_MUL_STEP:
            begin
                mul_a = MA_W'(t_reg);
                mul_b = 17'h10000 - {1'b0, step_mult_reg};
            end
            laev_pkg::OP_MUL_SAMPLE:
            begin
                mul_a = MA_W'(smp_abs);
                mul_b = {1'b0, level_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MW'(mul_a) * MW'(mul_b);

    // Round up after each scaling
    assign ax_sum     = {1'b0, prod_reg[31:0]} + 33'd4095;
    assign interp_sum = {1'b0, prod_reg[32:0]} + 34'd131071;
    assign t_interp   = {1'b0, lo_reg} + interp_sum[33:17];
    assign stepv_sum  = {1'b0, prod_reg[31:0]} + 33'd65535;
    assign stepv      = stepv_sum[32:16];
    assign level_up   = {1'b0, level_reg} + stepv;

    always_comb
    begin
        if (up_reg)
            level_upd = level_up[16] ? 16'hFFFF : level_up[15:0];
        else if (stepv > {1'b0, level_reg})
            level_upd = 16'd0;
        else
            level_upd = level_reg - stepv[15:0];
    end

    assign silent = level_reg <= silent_level_reg;

    always_comb
    begin
        stage_upd = stage_reg;
        sm_upd    = step_mult_reg;
        if (stage_upd == laev_pkg::STAGE_ATTACK && level_reg[15])
        begin
            stage_upd = laev_pkg::STAGE_RELEASE;
            sm_upd    = release_mult_reg;
        end
        if (stage_upd == laev_pkg::STAGE_RELEASE && silent)
        begin
            if (loop_enable_reg)
            begin
                stage_upd = laev_pkg::STAGE_ATTACK;
                sm_upd    = attack_mult_reg;
            end
            else
            begin
                stage_upd = laev_pkg::STAGE_IDLE;
            end
        end
        if (stage_upd == laev_pkg::STAGE_IDLE && loop_enable_reg && silent)
        begin
            stage_upd = laev_pkg::STAGE_ATTACK;
            sm_upd    = attack_mult_reg;
        end
    end

    // Scaled sample, rounded half away from zero, saturated
    assign mag_sum = {1'b0, prod_reg[SB+14:0]} + (SB+16)'(16384);
    assign mag     = mag_sum[SB+15:15];
    assign mag_neg = ~mag + 1'b1;

    always_comb
    begin
        if (!smp_neg && mag > POS_LIM)
            smp_res = SMAX;
        else if (smp_neg && mag > NEG_LIM)
            smp_res = SMIN;
        else if (smp_neg)
            smp_res = mag_neg[SB-1:0];
        else
            smp_res = mag[SB-1:0];
    end

    assign rom_addr = (uc.op == laev_pkg::OP_ROM_HI) ? (idx_reg + 1'b1)
                    : (clamp_reg ? LAST_ADDR : idx_reg);

    laev_tanh_rom #(
        .ENTRIES (TANH_ENTRIES)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    // Configuration port
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            laev_pkg::REG_ATTACK_MULT:  prdata = {16'd0, attack_mult_reg};
            laev_pkg::REG_RELEASE_MULT: prdata = {16'd0, release_mult_reg};
            laev_pkg::REG_LOOP_ENABLE:  prdata = {31'd0, loop_enable_reg};
            laev_pkg::REG_SILENT_LEVEL: prdata = {16'd0, silent_level_reg};
            laev_pkg::REG_KNEE_INVERSE: prdata = {16'd0, knee_inverse_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        attack_mult_next  = attack_mult_reg;
        release_mult_next = release_mult_reg;
        loop_enable_next  = loop_enable_reg;
        silent_level_next = silent_level_reg;
        knee_inverse_next = knee_inverse_reg;
        level_next        = level_reg;
        stage_next        = stage_reg;
        step_mult_next    = step_mult_reg;
        if (active)
        begin
            case (uc.op)
                laev_pkg::OP_CMD:
                begin
                    unique case (item_reg.cmd)
                        laev_pkg::CMD_ATTACK:
                        begin
                            stage_next     = laev_pkg::STAGE_ATTACK;
                            step_mult_next = attack_mult_reg;
                        end
                        laev_pkg::CMD_RELEASE:
                        begin
                            stage_next     = laev_pkg::STAGE_RELEASE;
                            step_mult_next = release_mult_reg;
                        end
                        laev_pkg::CMD_RESET:
                        begin
                            level_next     = 16'd0;
                            stage_next     = laev_pkg::STAGE_IDLE;
                            step_mult_next = 16'd0;
                        end
                        default: ;
                    endcase
                end
                laev_pkg::OP_LEVEL: level_next = level_upd;
                laev_pkg::OP_STAGE:
                begin
                    stage_next     = stage_upd;
                    step_mult_next = sm_upd;
                end
                default: ;
            endcase
        end
        if (cfg_we)
        begin
            unique case (cfg_idx)
                laev_pkg::REG_ATTACK_MULT:
                begin
                    attack_mult_next = pwdata[15:0];
                    if (stage_reg == laev_pkg::STAGE_ATTACK)
                        step_mult_next = pwdata[15:0];
                end
                laev_pkg::REG_RELEASE_MULT:
                begin
                    release_mult_next = pwdata[15:0];
                    if (stage_reg == laev_pkg::STAGE_RELEASE)
                        step_mult_next = pwdata[15:0];
                end
                laev_pkg::REG_LOOP_ENABLE:  loop_enable_next  = pwdata[0];
                laev_pkg::REG_SILENT_LEVEL: silent_level_next = pwdata[15:0];
                laev_pkg::REG_KNEE_INVERSE: knee_inverse_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= laev_pkg::S_WAIT;
            attack_mult_reg  <= laev_pkg::ATTACK_MULT_RST;
            release_mult_reg <= laev_pkg::RELEASE_MULT_RST;
            loop_enable_reg  <= laev_pkg::LOOP_ENABLE_RST;
            silent_level_reg <= laev_pkg::SILENT_LEVEL_RST;
            knee_inverse_reg <= laev_pkg::KNEE_INVERSE_RST;
            level_reg        <= 16'd0;
            stage_reg        <= laev_pkg::STAGE_IDLE;
            step_mult_reg    <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            attack_mult_reg  <= attack_mult_next;
            release_mult_reg <= release_mult_next;
            loop_enable_reg  <= loop_enable_next;
            silent_level_reg <= silent_level_next;
            knee_inverse_reg <= knee_inverse_next;
            level_reg        <= level_next;
            stage_reg        <= stage_next;
            step_mult_reg    <= step_mult_next;
            if (active && uc.op == laev_pkg::OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (active)
        begin
            case (uc.op) inside
                laev_pkg::OP_WAIT: item_reg <= in_data;
                laev_pkg::OP_CMD:
                begin
                    diff_reg <= diff_calc;
                    up_reg   <= stage_reg == laev_pkg::STAGE_ATTACK;
                end
                laev_pkg::OP_MUL_KNEE, laev_pkg::OP_MUL_N, laev_pkg::OP_MUL_D,
                laev_pkg::OP_MUL_STEP, laev_pkg::OP_MUL_SAMPLE:
                    prod_reg <= mul_p;
                laev_pkg::OP_AX: ax_reg <= ax_sum[32:12];
                laev_pkg::OP_INDEX:
                begin
                    idx_reg   <= prod_reg[17 +: IW];
                    rem_reg   <= prod_reg[16:0];
                    clamp_reg <= prod_reg[MW-1:17] >= LAST_IDX;
                end
                laev_pkg::OP_ROM_HI:
                begin
                    lo_reg <= rom_q;
                    t_reg  <= rom_q;
                end
                laev_pkg::OP_INTERP: t_reg <= t_interp[15:0];
                laev_pkg::OP_EMIT:
                begin
                    out_reg.sample_out <= smp_res;
                    out_reg.env_level  <= level_reg;
                    out_reg.env_stage  <= stage_reg;
                    out_reg.block_last <= item_reg.block_end;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new result only comes from the last program step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_reg) == laev_pkg::S_EMIT)
        else $error("result raised outside the emit step");

    // A command item returns to the wait step right after decode
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.cmd != laev_pkg::CMD_SAMPLE)
        |=> step_reg == laev_pkg::S_DECODE ##1 step_reg == laev_pkg::S_WAIT)
        else $error("command item did not finish in two cycles");

    // Between items the active multiplier follows the stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == laev_pkg::S_WAIT && stage_reg == laev_pkg::STAGE_ATTACK)
        |-> step_mult_reg == attack_mult_reg)
        else $error("attack multiplier out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == laev_pkg::S_WAIT && stage_reg == laev_pkg::STAGE_RELEASE)
        |-> step_mult_reg == release_mult_reg)
        else $error("release multiplier out of step");

    // A blocked result holds the program on its emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == laev_pkg::S_EMIT && out_valid && out_stall)
        |=> step_reg == laev_pkg::S_EMIT)
        else $error("emit step left while output blocked");

endmodule

`default_nettype wire
